[src/rrp_pkg.sv]
package rrp_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned NumSegs = 10;
  localparam int unsigned SegW    = $clog2(NumSegs);
  localparam int unsigned FracW   = 16;

  localparam logic [DataW-1:0] ONE_FIX = 32'h0001_0000;
  localparam logic [DataW-1:0] UNSPEC  = 32'hFFFF_0000;

  typedef enum logic [1:0] {
    SEG_MOVE  = 2'd0,
    SEG_LINE  = 2'd1,
    SEG_QUAD  = 2'd2,
    SEG_CLOSE = 2'd3
  } seg_e;

  typedef enum logic [2:0] {
    CFG_SCALE_XX = 3'd0,
    CFG_SHEAR_XY = 3'd1,
    CFG_OFFSET_X = 3'd2,
    CFG_SHEAR_YX = 3'd3,
    CFG_SCALE_YY = 3'd4,
    CFG_OFFSET_Y = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] top;
    logic signed [DataW-1:0] rect_width;
    logic signed [DataW-1:0] rect_height;
    logic signed [DataW-1:0] radius_x;
    logic signed [DataW-1:0] radius_y;
  } in_t;

  typedef struct packed {
    seg_e                    seg_type;
    logic signed [DataW-1:0] point0_x;
    logic signed [DataW-1:0] point0_y;
    logic signed [DataW-1:0] point1_x;
    logic signed [DataW-1:0] point1_y;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic signed [DataW-1:0] scale_xx;
    logic signed [DataW-1:0] shear_xy;
    logic signed [DataW-1:0] offset_x;
    logic signed [DataW-1:0] shear_yx;
    logic signed [DataW-1:0] scale_yy;
    logic signed [DataW-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] p0x;
    logic [DataW-1:0] p0y;
    logic [DataW-1:0] p1x;
    logic [DataW-1:0] p1y;
  } pts_t;

endpackage

[src/rounded_rect_path_generator.sv]
// Rounded rectangle path generator.
// One input transfer carries a rectangle (left, top, width, height and two
// corner radii in signed 16.16). The block answers with ten output transfers:
// move, line, quad, line, quad, line, quad, line, quad and close, the close
// carrying the last flag. Every point passes through the affine transform
// held in six registers written over the configuration port, which is always
// ready and must only be written while the block is idle.
// The first segment of a rectangle passes the input buffer, the segment
// sequencer, the segment stage, the product stage and the output register;
// segments then follow one per cycle while out_stall_i is low. A rectangle
// occupies the segment sequencer for its ten segments, and the next rectangle
// is taken while the previous one is still in the pipeline.
// Reset clears all valid bits and loads the identity transform.
// When out_stall_i is high with a segment pending, the whole pipeline holds;
// the input side takes one more rectangle into its buffer and then stalls.
module rounded_rect_path_generator
  import rrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [DataW-1:0] cfg_data_i
);

  localparam logic [SegW-1:0] LastSeg = SegW'(NumSegs - 1);

  cfg_t             cfg_q;
  logic             adv;
  logic             in_accept;
  logic             r0_valid_q;
  in_t              r0_q;
  logic             r1_valid_q;
  logic             r1_load;
  logic             issue;
  logic [SegW-1:0]  seg_q;
  logic [DataW-1:0] x_q, y_q, rx_q, ry_q, w_q, h_q;
  logic [DataW-1:0] rx_d, ry_d, w_d, h_d;
  logic             s2_valid_q;
  seg_e             s2_seg_q;
  seg_e             s2_seg_d;
  pts_t             s2_pts_q;
  pts_t             s2_pts_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scale_xx: ONE_FIX, shear_xy: '0, offset_x: '0,
                 shear_yx: '0, scale_yy: ONE_FIX, offset_y: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALE_XX: cfg_q.scale_xx <= cfg_data_i;
        CFG_SHEAR_XY: cfg_q.shear_xy <= cfg_data_i;
        CFG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        CFG_SHEAR_YX: cfg_q.shear_yx <= cfg_data_i;
        CFG_SCALE_YY: cfg_q.scale_yy <= cfg_data_i;
        CFG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_o || !out_stall_i;
  assign issue      = r1_valid_q && adv;
  assign r1_load    = r0_valid_q && (!r1_valid_q || (issue && seg_q == LastSeg));
  assign in_stall_o = r0_valid_q && !r1_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    logic signed [DataW-1:0] rx, ry, w, h, hw, hh;
    logic                    rx_un, ry_un;
    rx    = r0_q.radius_x;
    ry    = r0_q.radius_y;
    rx_un = (rx == $signed(UNSPEC));
    ry_un = (ry == $signed(UNSPEC));
    if ((rx_un && ry_un) || rx < $signed(UNSPEC) || ry < $signed(UNSPEC)) begin
      rx = '0;
      ry = '0;
    end else if (rx_un) begin
      rx = ry;
    end else if (ry_un) begin
      ry = rx;
    end
    w  = r0_q.rect_width[DataW-1] ? '0 : r0_q.rect_width;
    h  = r0_q.rect_height[DataW-1] ? '0 : r0_q.rect_height;
    hw = w >>> 1;
    hh = h >>> 1;
    rx_d = (rx > hw) ? hw : rx;
    ry_d = (ry > hh) ? hh : ry;
    w_d  = w;
    h_d  = h;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_valid_q <= 1'b0;
      r1_valid_q <= 1'b0;
      seg_q      <= '0;
    end else begin
      r0_valid_q <= in_accept || (r0_valid_q && !r1_load);
      if (r1_load) begin
        r1_valid_q <= 1'b1;
        seg_q      <= '0;
      end else if (issue) begin
        if (seg_q == LastSeg) begin
          r1_valid_q <= 1'b0;
          seg_q      <= '0;
        end else begin
          seg_q <= seg_q + SegW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      r0_q <= in_data_i;
    end
    if (r1_load) begin
      x_q  <= r0_q.left;
      y_q  <= r0_q.top;
      rx_q <= rx_d;
      ry_q <= ry_d;
      w_q  <= w_d;
      h_q  <= h_d;
    end
  end

  always_comb begin
    logic [DataW-1:0] xl, xr1, xr2, xe, yt, yb1, yb2, ye;
    xl       = x_q;
    xr1      = x_q + rx_q;
    xr2      = x_q + w_q - rx_q;
    xe       = x_q + w_q;
    yt       = y_q;
    yb1      = y_q + ry_q;
    yb2      = y_q + h_q - ry_q;
    ye       = y_q + h_q;
    s2_pts_d = '0;
    s2_seg_d = SEG_CLOSE;
    case (seg_q)
      4'd0: begin
        s2_seg_d     = SEG_MOVE;
        s2_pts_d.p0x = xr1;
        s2_pts_d.p0y = yt;
      end
      4'd1: begin
        s2_seg_d     = SEG_LINE;
        s2_pts_d.p0x = xr2;
        s2_pts_d.p0y = yt;
      end
      4'd2: begin
        s2_seg_d     = SEG_QUAD;
        s2_pts_d.p0x = xe;
        s2_pts_d.p0y = yt;
        s2_pts_d.p1x = xe;
        s2_pts_d.p1y = yb1;
      end
      4'd3: begin
        s2_seg_d     = SEG_LINE;
        s2_pts_d.p0x = xe;
        s2_pts_d.p0y = yb2;
      end
      4'd4: begin
        s2_seg_d     = SEG_QUAD;
        s2_pts_d.p0x = xe;
        s2_pts_d.p0y = ye;
        s2_pts_d.p1x = xr2;
        s2_pts_d.p1y = ye;
      end
      4'd5: begin
        s2_seg_d     = SEG_LINE;
        s2_pts_d.p0x = xr1;
        s2_pts_d.p0y = ye;
      end
      4'd6: begin
        s2_seg_d     = SEG_QUAD;
        s2_pts_d.p0x = xl;
        s2_pts_d.p0y = ye;
        s2_pts_d.p1x = xl;
        s2_pts_d.p1y = yb2;
      end
      4'd7: begin
        s2_seg_d     = SEG_LINE;
        s2_pts_d.p0x = xl;
        s2_pts_d.p0y = yb1;
      end
      4'd8: begin
        s2_seg_d     = SEG_QUAD;
        s2_pts_d.p0x = xl;
        s2_pts_d.p0y = yt;
        s2_pts_d.p1x = xr1;
        s2_pts_d.p1y = yt;
      end
      default: s2_seg_d = SEG_CLOSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= r1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_seg_q <= s2_seg_d;
      s2_pts_q <= s2_pts_d;
    end
  end

  rrp_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_valid_q),
    .seg_i   (s2_seg_q),
    .pts_i   (s2_pts_q),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_last_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.seg_type == SEG_CLOSE)))
    else $error("last flag does not match the close segment");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last) |->
      (out_data_o.point0_x == '0 && out_data_o.point0_y == '0 &&
       out_data_o.point1_x == '0 && out_data_o.point1_y == '0))
    else $error("close segment carries nonzero points");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1_valid_q |-> (seg_q <= LastSeg))
    else $error("segment counter out of range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r1_valid_q && !adv) |=> (r1_valid_q && $stable(seg_q)))
    else $error("segment sequencer moved during a stall");

endmodule

[src/rrp_xform.sv]
module rrp_xform
  import rrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  seg_e seg_i,
  input  pts_t pts_i,
  input  cfg_t cfg_i,
  output logic valid_o,
  output out_t data_o
);

  localparam int unsigned ProdW = 2 * DataW;

  logic                    prod_valid_q;
  seg_e                    prod_seg_q;
  logic [DataW-1:0]        prod_q [8];
  logic [DataW-1:0]        prod_d [8];
  logic                    out_valid_q;
  out_t                    out_q;
  out_t                    out_d;

  function automatic logic [DataW-1:0] fmul(logic signed [DataW-1:0] a,
                                            logic [DataW-1:0] b);
    logic signed [ProdW-1:0] p;
    p = $signed({{DataW{a[DataW-1]}}, a}) * $signed({{DataW{b[DataW-1]}}, b});
    return p[FracW+DataW-1:FracW];
  endfunction

  always_comb begin
    prod_d[0] = fmul(cfg_i.scale_xx, pts_i.p0x);
    prod_d[1] = fmul(cfg_i.shear_xy, pts_i.p0y);
    prod_d[2] = fmul(cfg_i.shear_yx, pts_i.p0x);
    prod_d[3] = fmul(cfg_i.scale_yy, pts_i.p0y);
    prod_d[4] = fmul(cfg_i.scale_xx, pts_i.p1x);
    prod_d[5] = fmul(cfg_i.shear_xy, pts_i.p1y);
    prod_d[6] = fmul(cfg_i.shear_yx, pts_i.p1x);
    prod_d[7] = fmul(cfg_i.scale_yy, pts_i.p1y);
  end

  always_comb begin
    out_d          = '0;
    out_d.seg_type = prod_seg_q;
    if (prod_seg_q == SEG_CLOSE) begin
      out_d.last = 1'b1;
    end else begin
      out_d.point0_x = prod_q[0] + prod_q[1] + cfg_i.offset_x;
      out_d.point0_y = prod_q[2] + prod_q[3] + cfg_i.offset_y;
      if (prod_seg_q == SEG_QUAD) begin
        out_d.point1_x = prod_q[4] + prod_q[5] + cfg_i.offset_x;
        out_d.point1_y = prod_q[6] + prod_q[7] + cfg_i.offset_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= valid_i;
      out_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_seg_q <= seg_i;
      prod_q     <= prod_d;
      out_q      <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
